@@ rtl/lppd_pkg.sv @@
// Package for the length-prefixed packet deframer: phase type, result kinds, register indexes.
`timescale 1ns / 1ps

package lppd_pkg;

   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_TYPE   = 3'd1,
      PH_DLEN   = 3'd2,
      PH_DATA   = 3'd3,
      PH_DYNLEN = 3'd4,
      PH_DYN    = 3'd5,
      PH_CRC    = 3'd6
   } phase_type;

   typedef logic [2:0] kind_type;

   localparam kind_type K_DATA    = 3'd0;
   localparam kind_type K_DYN     = 3'd1;
   localparam kind_type K_DONE    = 3'd2;
   localparam kind_type K_BADTYPE = 3'd3;
   localparam kind_type K_BADDLEN = 3'd4;
   localparam kind_type K_BADYLEN = 3'd5;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type CSR_START_WORD = 2'd0;
   localparam csr_index_type CSR_TYPE_COUNT = 2'd1;
   localparam csr_index_type CSR_MAX_LENGTH = 2'd2;

   localparam int CSR_DATA_WIDTH = 16;

   localparam logic [15:0] START_WORD_RESET = 16'd0;
   localparam logic [7:0]  TYPE_COUNT_RESET = 8'd8;
   localparam logic [15:0] MAX_LENGTH_RESET = 16'd4096;

endpackage

@@ rtl/length_prefixed_packet_deframer.sv @@
// Length-prefixed packet deframer: start-word hunt, header fields, tagged payload bytes.
// A byte is held in the input register and its result (if any) in the result register.
// Throughput: one byte per cycle unless stalled; state update is one register stage.
// An input register and a result register decouple the two sides.
// Reset (synchronous, active high) returns to hunting with nothing primed and
// loads the register defaults: start word 0, type count 8, max length 4096.
`timescale 1ns / 1ps

module length_prefixed_packet_deframer #(
   parameter int LENGTH_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // byte input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_in_byte,
   // results
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0]                          rsp_out_kind,
   output logic [7:0]                          rsp_out_byte,
   output logic [7:0]                          rsp_frame_type,
   output logic                                rsp_block_last,
   // configuration
   input  logic                                csr_we,
   input  lppd_pkg::csr_index_type             csr_index,
   input  logic [lppd_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   // configuration registers
   logic [15:0] start_word_ff;
   logic [7:0]  type_count_ff;
   logic [15:0] max_length_ff;

   // input stage
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;

   // parser state
   lppd_pkg::phase_type       phase_ff, phase_in;
   logic [7:0]                previous_byte_ff, previous_byte_in;
   logic [31:0]               field_shift_ff, field_shift_in;
   logic [1:0]                field_count_ff, field_count_in;
   logic [7:0]                current_type_ff, current_type_in;
   logic [LENGTH_WIDTH-1:0]   bytes_left_ff, bytes_left_in;
   logic                      hunt_primed_ff, hunt_primed_in;

   // result register
   logic                      rsp_valid_ff;
   lppd_pkg::kind_type        rsp_kind_ff, rsp_kind_in;
   logic [7:0]                rsp_byte_ff, rsp_byte_in;
   logic [7:0]                rsp_type_ff, rsp_type_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      res_valid;

   logic        out_ready;
   logic        step;
   logic [31:0] field_value;
   logic        field_done;
   logic        hunt_match;
   logic        type_bad;
   logic        len_bad;
   logic        block_last;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;

   // shared decode for the current byte
   assign field_value = field_shift_ff | ({24'd0, in_byte_ff} << {field_count_ff, 3'b000});
   assign field_done  = (field_count_ff == 2'd3);
   assign hunt_match  = hunt_primed_ff && ({in_byte_ff, previous_byte_ff} == start_word_ff);
   assign type_bad    = (field_value >= {24'd0, type_count_ff});
   // a length must fit the counter and stay within the limit
   assign len_bad     = ((field_value >> LENGTH_WIDTH) != 32'd0) ||
                        (field_value > {16'd0, max_length_ff});
   assign block_last  = (bytes_left_ff <= LENGTH_WIDTH'(1));

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         lppd_pkg::PH_HUNT: begin
            if (hunt_match) phase_in = lppd_pkg::PH_TYPE;
         end
         lppd_pkg::PH_TYPE: begin
            if (field_done) phase_in = type_bad ? lppd_pkg::PH_HUNT : lppd_pkg::PH_DLEN;
         end
         lppd_pkg::PH_DLEN: begin
            if (field_done) begin
               if (len_bad)                  phase_in = lppd_pkg::PH_HUNT;
               else if (field_value == 32'd0) phase_in = lppd_pkg::PH_DYNLEN;
               else                           phase_in = lppd_pkg::PH_DATA;
            end
         end
         lppd_pkg::PH_DYNLEN: begin
            if (field_done) begin
               if (len_bad)                  phase_in = lppd_pkg::PH_HUNT;
               else if (field_value == 32'd0) phase_in = lppd_pkg::PH_CRC;
               else                           phase_in = lppd_pkg::PH_DYN;
            end
         end
         lppd_pkg::PH_DATA: begin
            if (block_last) phase_in = lppd_pkg::PH_DYNLEN;
         end
         lppd_pkg::PH_DYN: begin
            if (block_last) phase_in = lppd_pkg::PH_CRC;
         end
         lppd_pkg::PH_CRC: begin
            if (field_done) phase_in = lppd_pkg::PH_HUNT;
         end
         default: phase_in = lppd_pkg::PH_HUNT;
      endcase
   end

   // datapath state and result
   always_comb begin
      previous_byte_in = previous_byte_ff;
      field_shift_in   = 32'd0;
      field_count_in   = 2'd0;
      current_type_in  = current_type_ff;
      bytes_left_in    = bytes_left_ff;
      hunt_primed_in   = hunt_primed_ff;
      res_valid        = 1'b0;
      rsp_kind_in      = lppd_pkg::K_DATA;
      rsp_byte_in      = 8'd0;
      rsp_type_in      = current_type_ff;
      rsp_last_in      = 1'b0;

      case (phase_ff)
         lppd_pkg::PH_HUNT: begin
            if (hunt_match) begin
               hunt_primed_in = 1'b0;
            end else begin
               previous_byte_in = in_byte_ff;
               hunt_primed_in   = 1'b1;
            end
         end
         lppd_pkg::PH_TYPE: begin
            if (!field_done) begin
               field_shift_in = field_value;
               field_count_in = field_count_ff + 2'd1;
            end else if (type_bad) begin
               res_valid   = 1'b1;
               rsp_kind_in = lppd_pkg::K_BADTYPE;
               rsp_type_in = field_value[7:0];
            end else begin
               current_type_in = field_value[7:0];
            end
         end
         lppd_pkg::PH_DLEN, lppd_pkg::PH_DYNLEN: begin
            if (!field_done) begin
               field_shift_in = field_value;
               field_count_in = field_count_ff + 2'd1;
            end else if (len_bad) begin
               res_valid   = 1'b1;
               rsp_kind_in = (phase_ff == lppd_pkg::PH_DLEN) ? lppd_pkg::K_BADDLEN
                                                             : lppd_pkg::K_BADYLEN;
            end else begin
               bytes_left_in = field_value[LENGTH_WIDTH-1:0];
            end
         end
         lppd_pkg::PH_DATA, lppd_pkg::PH_DYN: begin
            res_valid     = 1'b1;
            rsp_kind_in   = (phase_ff == lppd_pkg::PH_DATA) ? lppd_pkg::K_DATA
                                                            : lppd_pkg::K_DYN;
            rsp_byte_in   = in_byte_ff;
            rsp_last_in   = block_last;
            bytes_left_in = block_last ? '0 : bytes_left_ff - LENGTH_WIDTH'(1);
         end
         lppd_pkg::PH_CRC: begin
            if (!field_done) begin
               field_shift_in = field_value;
               field_count_in = field_count_ff + 2'd1;
            end else begin
               res_valid   = 1'b1;
               rsp_kind_in = lppd_pkg::K_DONE;
            end
         end
         default: begin
            hunt_primed_in = 1'b0;
         end
      endcase

      // every return to hunting starts unprimed
      if (phase_ff != lppd_pkg::PH_HUNT && phase_in == lppd_pkg::PH_HUNT) begin
         hunt_primed_in = 1'b0;
      end
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         start_word_ff <= lppd_pkg::START_WORD_RESET;
         type_count_ff <= lppd_pkg::TYPE_COUNT_RESET;
         max_length_ff <= lppd_pkg::MAX_LENGTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            lppd_pkg::CSR_START_WORD: start_word_ff <= csr_wdata[15:0];
            lppd_pkg::CSR_TYPE_COUNT: type_count_ff <= csr_wdata[7:0];
            lppd_pkg::CSR_MAX_LENGTH: max_length_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= lppd_pkg::PH_HUNT;
         previous_byte_ff <= 8'd0;
         field_shift_ff   <= 32'd0;
         field_count_ff   <= 2'd0;
         current_type_ff  <= 8'd0;
         bytes_left_ff    <= '0;
         hunt_primed_ff   <= 1'b0;
      end else if (step) begin
         phase_ff         <= phase_in;
         previous_byte_ff <= previous_byte_in;
         field_shift_ff   <= field_shift_in;
         field_count_ff   <= field_count_in;
         current_type_ff  <= current_type_in;
         bytes_left_ff    <= bytes_left_in;
         hunt_primed_ff   <= hunt_primed_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= step && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_byte_ff <= rsp_byte_in;
         rsp_type_ff <= rsp_type_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_kind   = rsp_kind_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_frame_type = rsp_type_ff;
   assign rsp_block_last = rsp_last_ff;

endmodule
